// ===== hw/rtl/brsd_pkg.sv =====
// ----------------------------------------------------------------------------
// brsd_pkg
// shared types, codes and constants of the bmp rle span decoder
// ----------------------------------------------------------------------------
`default_nettype none

package brsd_pkg;

	// bitmap side bound, registers are clamped to one below it
	localparam int MAX_SIDE = 16384;
	localparam int SIDE_W   = 14;
	localparam int ADDR_W   = 28;
	localparam int BASE_W   = 30;
	localparam int COL_W    = 24;

	// low nibble of a pixel byte
	localparam logic [7:0] NIB_MASK = 8'h0F;

	// escape codes following a zero count byte
	localparam logic [7:0] ESC_EOL   = 8'd0;
	localparam logic [7:0] ESC_EOB   = 8'd1;
	localparam logic [7:0] ESC_DELTA = 8'd2;

	// register indexes
	typedef enum logic [1:0] {
		REG_NIBBLE = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} brsd_reg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_end;
	} brsd_in_t;

	typedef struct packed {
		logic              span_valid;
		logic [ADDR_W-1:0] span_start;
		logic [7:0]        span_length;
		logic [7:0]        first_index;
		logic [7:0]        second_index;
		logic              clipped;
		logic              finished;
		logic              failed;
	} brsd_out_t;

	// geometry handed from the register block to the parser
	typedef struct packed {
		logic                     nibble_mode;
		logic [SIDE_W-1:0]        side_w;
		logic signed [BASE_W-1:0] base0;
		logic [ADDR_W-1:0]        total;
		logic                     busy;
		logic                     reload;
	} brsd_geom_t;

	function automatic logic [SIDE_W-1:0] side_clamp(input logic [SIDE_W-1:0] v);
		if ({{(32-SIDE_W){1'b0}}, v} > 32'(MAX_SIDE - 1))
			return SIDE_W'(MAX_SIDE - 1);
		else
			return v;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/brsd_geom.sv =====
// ----------------------------------------------------------------------------
// brsd_geom
// configuration registers and registered bitmap geometry products
// ----------------------------------------------------------------------------
`default_nettype none

module brsd_geom
	import brsd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [SIDE_W-1:0] cfg_data,
	output brsd_geom_t             geom
);

	logic                     nibble_q;
	logic [SIDE_W-1:0]        width_q;
	logic [SIDE_W-1:0]        height_q;
	logic                     pend_q;
	logic                     load_q;
	logic signed [BASE_W-1:0] base0_q;
	logic [ADDR_W-1:0]        total_q;

	logic signed [SIDE_W+1:0] hm1;
	logic signed [2*SIDE_W+2:0] base_prod;
	logic [2*SIDE_W-1:0]      total_prod;
	logic                     wr_hit;

	assign cfg_ready = 1'b1;

	always_comb begin
		hm1        = $signed({2'b00, height_q}) - (SIDE_W+2)'(1);
		base_prod  = hm1 * $signed({1'b0, width_q});
		total_prod = (2*SIDE_W)'(height_q) * (2*SIDE_W)'(width_q);
		case (cfg_index)
			REG_NIBBLE, REG_WIDTH, REG_HEIGHT: wr_hit = cfg_valid;
			default:                           wr_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nibble_q <= 1'b0;
			width_q  <= SIDE_W'(1);
			height_q <= SIDE_W'(1);
			pend_q   <= 1'b0;
			load_q   <= 1'b0;
			base0_q  <= '0;
			total_q  <= ADDR_W'(1);
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_NIBBLE: nibble_q <= cfg_data[0];
					REG_WIDTH:  width_q  <= side_clamp(cfg_data);
					REG_HEIGHT: height_q <= side_clamp(cfg_data);
					default: ;
				endcase
			end
			// products are registered once pend_q follows a write, parser reloads on load_q
			pend_q <= wr_hit;
			load_q <= pend_q;
			if (pend_q) begin
				base0_q <= base_prod[BASE_W-1:0];
				total_q <= total_prod[ADDR_W-1:0];
			end
		end
	end

	always_comb begin
		geom.nibble_mode = nibble_q;
		geom.side_w      = width_q;
		geom.base0       = base0_q;
		geom.total       = total_q;
		geom.busy        = pend_q | load_q | wr_hit;
		geom.reload      = load_q;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/brsd_parse.sv =====
// ----------------------------------------------------------------------------
// brsd_parse
// byte parser, cursor update, span clipping and result register
// ----------------------------------------------------------------------------
`default_nettype none

module brsd_parse
	import brsd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire brsd_geom_t geom,
	input  wire logic       code_valid,
	output logic            code_ready,
	input  wire brsd_in_t   code_item,
	output logic            result_valid,
	input  wire logic       result_ready,
	output brsd_out_t       result
);

	typedef enum logic [2:0] {
		P_COUNT,
		P_RUNPIX,
		P_ESCAPE,
		P_DX,
		P_DY,
		P_ABS,
		P_PAD
	} phase_t;

	localparam int SUM_W = BASE_W + 1;
	localparam logic signed [SUM_W-1:0] ROW_FLOOR = -(SUM_W'(1) <<< (BASE_W - 1));

	// input stage and decoder state
	logic                     vld_s1;
	brsd_in_t                 item_s1;
	phase_t                   phase_q;
	logic [7:0]               run_left_q;
	logic                     pad_q;
	logic [7:0]               run_count_q;
	logic signed [BASE_W-1:0] row_q;
	logic [COL_W-1:0]         col_q;
	logic                     res_valid_q;
	brsd_out_t                res_q;

	logic       adv;
	logic       fire;
	logic [7:0] b;
	logic [7:0] lo_b;
	logic [8:0] b_inc;
	logic [7:0] nib_a;
	logic [7:0] nib_b;
	logic       last;
	logic       done;
	logic       span_req;
	logic [7:0] span_len;
	logic [7:0] idx_a;
	logic [7:0] idx_b;
	logic [7:0] abs_n;
	logic       col_en;
	logic       col_clr;
	logic       row_en;
	logic       res_en;

	phase_t     phase_n;
	logic [7:0] run_left_n;
	logic       pad_n;
	logic [7:0] run_count_n;

	logic [7:0]              rows;
	logic [SIDE_W+7:0]       row_prod;
	logic signed [SUM_W-1:0] row_sub;
	logic [BASE_W-1:0]       row_sat;
	logic [7:0]              col_step;
	logic [COL_W:0]          col_sum;
	logic [COL_W-1:0]        col_sat;

	logic signed [SUM_W-1:0] addr_a;
	logic signed [SUM_W-1:0] addr_e;
	logic signed [SUM_W-1:0] lo_v;
	logic signed [SUM_W-1:0] hi_v;
	logic signed [SUM_W-1:0] tot;
	logic [SUM_W-1:0]        diff;
	logic                    span_ok;
	logic                    swap;
	brsd_out_t               res_n;

	assign adv        = !res_valid_q || result_ready;
	assign fire       = vld_s1 && adv;
	assign code_ready = !geom.busy && (!vld_s1 || adv);

	always_comb begin
		b     = item_s1.data_byte;
		last  = item_s1.stream_end;
		lo_b  = b & NIB_MASK;
		b_inc = {1'b0, b} + 9'd1;
		nib_a = {4'b0000, b[7:4]};
		nib_b = lo_b;

		phase_n     = phase_q;
		run_left_n  = run_left_q;
		pad_n       = pad_q;
		run_count_n = run_count_q;
		done        = 1'b0;
		span_req    = 1'b0;
		span_len    = 8'd0;
		col_en      = 1'b0;
		col_clr     = 1'b0;
		row_en      = 1'b0;
		idx_a       = geom.nibble_mode ? nib_a : b;
		idx_b       = geom.nibble_mode ? nib_b : b;
		abs_n       = (geom.nibble_mode && run_left_q >= 8'd2) ? 8'd2 : 8'd1;

		case (phase_q)
			P_RUNPIX: begin
				span_req = 1'b1;
				span_len = run_count_q;
				phase_n  = P_COUNT;
			end
			P_ESCAPE: begin
				case (b)
					ESC_EOL: begin
						col_clr = 1'b1;
						row_en  = 1'b1;
						phase_n = P_COUNT;
					end
					ESC_EOB:   done    = 1'b1;
					ESC_DELTA: phase_n = P_DX;
					default: begin
						run_left_n = b;
						// absolute runs are padded to an even byte count
						pad_n      = geom.nibble_mode ? b_inc[1] : b[0];
						phase_n    = P_ABS;
					end
				endcase
			end
			P_DX: begin
				col_en  = 1'b1;
				phase_n = P_DY;
			end
			P_DY: begin
				row_en  = 1'b1;
				phase_n = P_COUNT;
			end
			P_ABS: begin
				span_req   = 1'b1;
				span_len   = abs_n;
				run_left_n = (run_left_q > abs_n) ? run_left_q - abs_n : 8'd0;
				if (run_left_n == 8'd0)
					phase_n = pad_q ? P_PAD : P_COUNT;
			end
			P_PAD: begin
				pad_n   = 1'b0;
				phase_n = P_COUNT;
			end
			default: begin
				if (b != 8'd0) begin
					run_count_n = b;
					phase_n     = P_RUNPIX;
				end else begin
					phase_n = P_ESCAPE;
				end
			end
		endcase

		// row move: one row for end of line, delta rows otherwise
		rows     = (phase_q == P_ESCAPE) ? 8'd1 : b;
		row_prod = (SIDE_W+8)'(rows) * (SIDE_W+8)'(geom.side_w);
		row_sub  = $signed({row_q[BASE_W-1], row_q})
			- $signed({{(SUM_W-SIDE_W-8){1'b0}}, row_prod});
		row_sat  = (row_sub < ROW_FLOOR) ? ROW_FLOOR[BASE_W-1:0] : row_sub[BASE_W-1:0];

		// column advance saturates
		col_step = span_req ? span_len : b;
		col_sum  = {1'b0, col_q} + {{(COL_W-7){1'b0}}, col_step};
		col_sat  = col_sum[COL_W] ? '1 : col_sum[COL_W-1:0];

		// clip the span to the whole bitmap range
		addr_a  = $signed({row_q[BASE_W-1], row_q}) + $signed({{(SUM_W-COL_W){1'b0}}, col_q});
		addr_e  = addr_a + $signed({{(SUM_W-8){1'b0}}, span_len});
		tot     = $signed({{(SUM_W-ADDR_W){1'b0}}, geom.total});
		lo_v    = addr_a[SUM_W-1] ? '0 : addr_a;
		hi_v    = (addr_e > tot) ? tot : addr_e;
		span_ok = hi_v > lo_v;
		diff    = hi_v - lo_v;
		// odd number dropped at the front swaps the alternating indices
		swap    = lo_v[0] ^ addr_a[0];

		res_n = '0;
		if (span_req && span_ok) begin
			res_n.span_valid   = 1'b1;
			res_n.span_start   = lo_v[ADDR_W-1:0];
			res_n.span_length  = diff[7:0];
			res_n.first_index  = swap ? idx_b : idx_a;
			res_n.second_index = swap ? idx_a : idx_b;
		end
		res_n.clipped  = span_req && (!span_ok || diff != {{(SUM_W-8){1'b0}}, span_len});
		res_n.finished = done;
		res_n.failed   = last && !done;
		res_en         = span_req || done || last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			phase_q     <= P_COUNT;
			run_left_q  <= 8'd0;
			pad_q       <= 1'b0;
			run_count_q <= 8'd0;
			row_q       <= '0;
			col_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// a fired item leaves the stage even while the input is held off
			if (code_ready)
				vld_s1 <= code_valid;
			else if (fire)
				vld_s1 <= 1'b0;
			if (adv)
				res_valid_q <= fire && res_en;
			if (geom.reload || (fire && (done || last))) begin
				phase_q     <= P_COUNT;
				run_left_q  <= 8'd0;
				pad_q       <= 1'b0;
				run_count_q <= 8'd0;
				row_q       <= geom.base0;
				col_q       <= '0;
			end else if (fire) begin
				phase_q     <= phase_n;
				run_left_q  <= run_left_n;
				pad_q       <= pad_n;
				run_count_q <= run_count_n;
				if (row_en)
					row_q <= row_sat;
				if (col_clr)
					col_q <= '0;
				else if (col_en || span_req)
					col_q <= col_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (code_ready)
			item_s1 <= code_item;
		if (adv)
			res_q <= res_n;
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_span_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.span_valid |-> res_q.span_length != 8'd0)
		else $error("written span with zero length");

	a_span_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.span_valid |->
			({1'b0, res_q.span_start} + (ADDR_W+1)'(res_q.span_length))
				<= {1'b0, geom.total})
		else $error("span reaches past the bitmap");

	a_end_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.finished && res_q.failed))
		else $error("finished and failed together");

	a_result_taken: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_en |=> res_valid_q)
		else $error("result of an item lost");

	a_restart_col: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (done || last) |=> col_q == '0 && phase_q == P_COUNT)
		else $error("cursor not restarted after end of stream");

endmodule

`default_nettype wire

// ===== hw/rtl/bmp_rle_span_decoder.sv =====
// ----------------------------------------------------------------------------
// bmp_rle_span_decoder
// decodes a bmp rle8/rle4 byte stream into clipped pixel spans
// ----------------------------------------------------------------------------
// usage
//   code channel   : one compressed byte per item, with a last-byte mark
//   result channel : one span item per pixel-carrying byte, end of bitmap or
//                    last byte; other bytes only move the cursor
//   cfg channel    : index 0 nibble mode, 1 width, 2 height; always ready,
//                    higher indexes are ignored
// throughput: one byte per cycle while results are taken and no register
//   write is pending; the cursor update and clip is one short combinational
//   step between the input stage and the result register
// a register write holds code_ready low in its own cycle and while pend_q and
//   load_q are set, as the row base (height-1)*width and the pixel count
//   width*height are registered; then the cursor restarts at the top stored row
// reset: width and height are 1, rle8 mode, cursor at address 0
// a stalled result register stops the parser; a byte is still taken into an
//   empty input stage, after that code_ready drops until the result is taken
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_rle_span_decoder
	import brsd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// compressed bytes
	input  wire logic              code_valid,
	output logic                   code_ready,
	input  wire brsd_in_t          code_item,
	// decoded spans
	output logic                   result_valid,
	input  wire logic              result_ready,
	output brsd_out_t              result,
	// register writes
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [SIDE_W-1:0] cfg_data
);

	// geometry and reload control from the register block
	brsd_geom_t geom;

	// register block: clamps sides and registers the two products
	brsd_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom)
	);

	// parser: input stage, cursor state and result register
	brsd_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.geom         (geom),
		.code_valid   (code_valid),
		.code_ready   (code_ready),
		.code_item    (code_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire
